// ===== sv/ihu_pkg.sv =====
// Shared types and constants for the indexed min-heap unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package ihu_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int POS_W      = $clog2(HEAP_DEPTH + 1);
    localparam int SLOT_AW    = $clog2(HEAP_DEPTH);
    localparam int ID_W       = 8;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POPMIN = 2'd1;
    localparam logic [1:0] KIND_SETKEY = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ID_W-1:0]    id;
        logic signed [31:0] key;
        logic [31:0]        payload;
    } heap_cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [ID_W-1:0]    out_id;
        logic signed [31:0] out_key;
        logic [31:0]        out_payload;
        logic [8:0]         entry_count;
    } heap_rsp_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [ID_W-1:0]    id;
        logic [31:0]        payload;
    } slot_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_FINISH,
        DP_INS_BEGIN,
        DP_LOOKUP,
        DP_POP_RD,
        DP_TAKE,
        DP_SETK,
        DP_UP_RD,
        DP_UP_STEP,
        DP_DN_RD,
        DP_DN_STEP,
        DP_PLACE
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] status;
    } dp_ctl_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       empty;
        logic       pt_hit;
        logic       is_root;
        logic       has_child;
        logic       up_less;
        logic       dn_less;
        logic       set_up;
        logic       take_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/ihu_datapath.sv =====
// Datapath of the indexed min-heap unit: slot memory, id position table,
// fill count, capacity register and result register. Depends on ihu_pkg.
`default_nettype none

module ihu_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ihu_pkg::heap_cmd_t cmd,
    input  wire ihu_pkg::dp_ctl_t   ctl,
    output ihu_pkg::dp_status_t     st,
    input  wire logic               cfg_valid,
    input  wire logic [8:0]         cfg_data,
    output ihu_pkg::heap_rsp_t      result,
    output logic                    done
);
    import ihu_pkg::*;

    slot_t               slot_mem [HEAP_DEPTH];
    logic [POS_W-1:0]    pos_mem  [HEAP_DEPTH];
    logic [HEAP_DEPTH-1:0] pt_valid_reg;

    heap_cmd_t           item_reg;
    slot_t               entry_reg, entry_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    fill_reg, fill_next;
    logic [8:0]          cap_reg;
    logic [POS_W-1:0]    pt_q_reg;
    logic                pt_v_reg;
    slot_t               qa_reg, qb_reg;
    heap_rsp_t           result_reg;
    logic                done_reg;

    logic [POS_W:0]      two_pos;
    logic [POS_W-1:0]    rd_a_pos, rd_b_pos;
    logic [POS_W-1:0]    cap_eff;
    logic                use_b;
    slot_t               child;
    logic [POS_W-1:0]    child_pos;

    logic                sl_we;
    logic [POS_W-1:0]    sl_wpos;
    slot_t               sl_wdata;
    logic                pt_we;
    logic [ID_W-1:0]     pt_wid;
    logic                pt_wval;

    assign two_pos = {pos_reg, 1'b0};
    assign cap_eff = (cap_reg > 9'(HEAP_DEPTH)) ? POS_W'(HEAP_DEPTH) : POS_W'(cap_reg);

    // right child wins only when it exists and is strictly smaller
    assign use_b     = ((two_pos + 1'b1) <= {1'b0, fill_reg}) && (qb_reg.key < qa_reg.key);
    assign child     = use_b ? qb_reg : qa_reg;
    assign child_pos = use_b ? POS_W'(two_pos + 1'b1) : POS_W'(two_pos);

    always_comb
    begin
        st.kind      = item_reg.kind;
        st.full      = fill_reg >= cap_eff;
        st.empty     = fill_reg == '0;
        st.pt_hit    = pt_v_reg;
        st.is_root   = pos_reg == POS_W'(1);
        st.has_child = two_pos <= {1'b0, fill_reg};
        st.up_less   = entry_reg.key < qa_reg.key;
        st.dn_less   = child.key < entry_reg.key;
        st.set_up    = item_reg.key < qa_reg.key;
        st.take_last = pos_reg == fill_reg;
    end

    // slot read addresses, data lands in qa/qb in the next cycle
    always_comb
    begin
        rd_a_pos = POS_W'(1);
        rd_b_pos = fill_reg;
        unique case (ctl.op)
            DP_LOOKUP: rd_a_pos = pt_q_reg;
            DP_POP_RD: rd_a_pos = POS_W'(1);
            DP_UP_RD:  rd_a_pos = pos_reg >> 1;
            DP_DN_RD:
            begin
                rd_a_pos = POS_W'(two_pos);
                rd_b_pos = POS_W'(two_pos + 1'b1);
            end
            default:   rd_a_pos = pos_reg;
        endcase
    end

    always_comb
    begin
        sl_we    = 1'b0;
        sl_wpos  = pos_reg;
        sl_wdata = entry_reg;
        pt_we    = 1'b0;
        pt_wid   = entry_reg.id;
        pt_wval  = 1'b1;
        unique case (ctl.op)
            DP_UP_STEP:
            begin
                sl_we    = st.up_less;
                sl_wdata = qa_reg;
                pt_we    = st.up_less;
                pt_wid   = qa_reg.id;
            end
            DP_DN_STEP:
            begin
                sl_we    = st.dn_less;
                sl_wdata = child;
                pt_we    = st.dn_less;
                pt_wid   = child.id;
            end
            DP_PLACE:
            begin
                sl_we = 1'b1;
                pt_we = 1'b1;
            end
            DP_TAKE:
            begin
                pt_we   = 1'b1;
                pt_wid  = qa_reg.id;
                pt_wval = 1'b0;
            end
            default:
            begin
                sl_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        entry_next = entry_reg;
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        unique case (ctl.op)
            DP_INS_BEGIN:
            begin
                fill_next  = fill_reg + 1'b1;
                pos_next   = fill_reg + 1'b1;
                entry_next = '{key: item_reg.key, id: item_reg.id, payload: item_reg.payload};
            end
            DP_LOOKUP:  pos_next = pt_q_reg;
            DP_POP_RD:  pos_next = POS_W'(1);
            DP_TAKE:
            begin
                fill_next  = fill_reg - 1'b1;
                entry_next = qb_reg;
            end
            DP_SETK:
                entry_next = '{key: item_reg.key, id: qa_reg.id, payload: qa_reg.payload};
            DP_UP_STEP:
                if (st.up_less)
                begin
                    pos_next = pos_reg >> 1;
                end
            DP_DN_STEP:
                if (st.dn_less)
                begin
                    pos_next = child_pos;
                end
            default:    pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sl_we)
        begin
            slot_mem[SLOT_AW'(sl_wpos - 1'b1)] <= sl_wdata;
        end
        qa_reg <= slot_mem[SLOT_AW'(rd_a_pos - 1'b1)];
        qb_reg <= slot_mem[SLOT_AW'(rd_b_pos - 1'b1)];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we && pt_wval)
        begin
            pos_mem[pt_wid] <= sl_wpos;
        end
        if (ctl.op == DP_LATCH)
        begin
            pt_q_reg <= pos_mem[cmd.id];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_valid_reg <= '0;
            pt_v_reg     <= 1'b0;
            fill_reg     <= '0;
            cap_reg      <= 9'(HEAP_DEPTH);
            done_reg     <= 1'b0;
        end
        else
        begin
            if (pt_we)
            begin
                pt_valid_reg[pt_wid] <= pt_wval;
            end
            if (ctl.op == DP_LATCH)
            begin
                pt_v_reg <= pt_valid_reg[cmd.id];
            end
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            fill_reg <= fill_next;
            done_reg <= (ctl.op == DP_FINISH) || (ctl.op == DP_PLACE);
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg   <= pos_next;
        entry_reg <= entry_next;
        if (ctl.op == DP_LATCH)
        begin
            item_reg               <= cmd;
            result_reg.out_id      <= '0;
            result_reg.out_key     <= '0;
            result_reg.out_payload <= '0;
        end
        if (ctl.op == DP_TAKE)
        begin
            result_reg.out_id      <= qa_reg.id;
            result_reg.out_key     <= qa_reg.key;
            result_reg.out_payload <= qa_reg.payload;
        end
        if (ctl.op == DP_FINISH)
        begin
            result_reg.status      <= ctl.status;
            result_reg.entry_count <= 9'(fill_reg);
        end
        if (ctl.op == DP_PLACE)
        begin
            result_reg.status      <= ST_OK;
            result_reg.entry_count <= 9'(fill_reg);
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= POS_W'(HEAP_DEPTH))
        else $error("fill count above heap depth");
    a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == DP_TAKE) |-> (fill_reg != '0))
        else $error("entry taken from empty heap");
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == DP_INS_BEGIN) |=> (fill_reg <= cap_eff))
        else $error("insert exceeded capacity");
`endif

endmodule

`default_nettype wire

// ===== sv/ihu_ctrl.sv =====
// Sequencer of the indexed min-heap unit: decodes the operation and walks
// the sift loops through datapath commands. Depends on ihu_pkg.
`default_nettype none

module ihu_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ihu_pkg::dp_status_t st,
    output ihu_pkg::dp_ctl_t         ctl
);
    import ihu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAKE,
        S_SETK,
        S_UP_RD,
        S_UP_STEP,
        S_DN_RD,
        S_DN_STEP,
        S_PLACE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   try_reg, try_next;  // moved-in entry: fall back to sift down

    always_comb
    begin
        state_next = state_reg;
        try_next   = try_reg;
        ctl.op     = DP_NOP;
        ctl.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
                if (start)
                begin
                    ctl.op     = DP_LATCH;
                    state_next = S_DISPATCH;
                end
            S_DISPATCH:
            begin
                unique case (st.kind)
                    KIND_INSERT:
                        priority if (st.full)
                        begin
                            ctl.op = DP_FINISH; ctl.status = ST_FULL; state_next = S_IDLE;
                        end
                        else if (st.pt_hit)
                        begin
                            ctl.op = DP_FINISH; ctl.status = ST_DUP; state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.op = DP_INS_BEGIN; try_next = 1'b0; state_next = S_UP_RD;
                        end
                    KIND_POPMIN:
                        if (st.empty)
                        begin
                            ctl.op = DP_FINISH; ctl.status = ST_EMPTY; state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.op = DP_POP_RD; state_next = S_TAKE;
                        end
                    default:
                        if (!st.pt_hit)
                        begin
                            ctl.op = DP_FINISH; ctl.status = ST_NOTFOUND; state_next = S_IDLE;
                        end
                        else
                        begin
                            ctl.op     = DP_LOOKUP;
                            state_next = (st.kind == KIND_SETKEY) ? S_SETK : S_TAKE;
                        end
                endcase
            end
            S_TAKE:
            begin
                ctl.op     = DP_TAKE;
                try_next   = 1'b1;
                state_next = st.take_last ? S_DONE : S_UP_RD;
            end
            S_SETK:
            begin
                ctl.op     = DP_SETK;
                try_next   = 1'b0;
                state_next = st.set_up ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD:
                if (st.is_root)
                begin
                    state_next = try_reg ? S_DN_RD : S_PLACE;
                end
                else
                begin
                    ctl.op     = DP_UP_RD;
                    state_next = S_UP_STEP;
                end
            S_UP_STEP:
            begin
                ctl.op = DP_UP_STEP;
                if (st.up_less)
                begin
                    try_next   = 1'b0;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = try_reg ? S_DN_RD : S_PLACE;
                end
            end
            S_DN_RD:
                if (!st.has_child)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    ctl.op     = DP_DN_RD;
                    state_next = S_DN_STEP;
                end
            S_DN_STEP:
            begin
                ctl.op     = DP_DN_STEP;
                state_next = st.dn_less ? S_DN_RD : S_PLACE;
            end
            S_PLACE:
            begin
                ctl.op     = DP_PLACE;
                state_next = S_IDLE;
            end
            S_DONE:
            begin
                ctl.op     = DP_FINISH;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            try_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            try_reg   <= try_next;
        end
    end

    assign busy = state_reg != S_IDLE;

`ifndef SYNTHESIS
    a_start_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_DISPATCH))
        else $error("accepted beat not dispatched");
    a_up_step_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_STEP) |-> ($past(state_reg) == S_UP_RD))
        else $error("up step without parent read");
    a_dn_step_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DN_STEP) |-> ($past(state_reg) == S_DN_RD))
        else $error("down step without child read");
`endif

endmodule

`default_nettype wire

// ===== sv/indexed_min_heap_unit.sv =====
// Top level of the indexed min-heap unit: sequencer plus datapath.
// Depends on ihu_pkg, ihu_ctrl and ihu_datapath.
//
// One operation is taken when start is high and busy is low; its result
// appears for exactly one cycle with done high and cannot be held off.
// An error result is given straight from the dispatch state. A successful
// operation takes, for every heap level an entry moves, a registered
// slot-memory read and then a compare and write back. A full 256-entry
// heap has eight levels to walk. busy drops as done rises, so the next
// start may be taken in the done cycle. The capacity register is written
// through cfg_valid/cfg_data; write it only while the unit is idle, as the
// unit itself does not enforce this. cfg_ready is always high.
`default_nettype none

module indexed_min_heap_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ihu_pkg::heap_cmd_t cmd,
    output ihu_pkg::heap_rsp_t      result,
    output logic                    done,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [8:0]         cfg_data
);
    import ihu_pkg::*;

    dp_ctl_t    ctl;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    ihu_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .ctl   (ctl)
    );

    ihu_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .st        (st),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .result    (result),
        .done      (done)
    );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for indexed_min_heap_unit: command driver, result monitor
// and a behavioral heap predictor. Depends on ihu_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb;
    import ihu_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    heap_cmd_t cmd = '0;
    heap_rsp_t result;
    logic      done;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [8:0] cfg_data = '0;

    indexed_min_heap_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result(result), .done(done), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // predictor state
    logic signed [31:0] hp_key [1:HEAP_DEPTH];
    logic [7:0]         hp_id  [1:HEAP_DEPTH];
    logic [31:0]        hp_pl  [1:HEAP_DEPTH];
    int unsigned        id_slot [0:255];
    int unsigned        heap_fill;
    int unsigned        cap_reg;

    heap_cmd_t cmd_queue [$];
    heap_rsp_t rsp_expected [$];
    int  errors;
    int  send_idle_pct;
    bit  drain_hold;
    longint cycles;

    function automatic void put_entry(int unsigned p, logic signed [31:0] k,
                                      logic [7:0] i, logic [31:0] d);
        hp_key[p] = k; hp_id[p] = i; hp_pl[p] = d; id_slot[i] = p;
    endfunction

    function automatic void bubble_up(int unsigned p);
        logic signed [31:0] k;
        logic [7:0] i;
        logic [31:0] d;
        k = hp_key[p]; i = hp_id[p]; d = hp_pl[p];
        while (p > 1 && k < hp_key[p/2]) begin
            put_entry(p, hp_key[p/2], hp_id[p/2], hp_pl[p/2]);
            p = p / 2;
        end
        put_entry(p, k, i, d);
    endfunction

    function automatic void bubble_down(int unsigned p);
        logic signed [31:0] k;
        logic [7:0] i;
        logic [31:0] d;
        int unsigned c;
        k = hp_key[p]; i = hp_id[p]; d = hp_pl[p];
        while (p * 2 <= heap_fill) begin
            c = p * 2;
            if (c < heap_fill && hp_key[c+1] < hp_key[c]) c++;
            if (!(hp_key[c] < k)) break;
            put_entry(p, hp_key[c], hp_id[c], hp_pl[c]);
            p = c;
        end
        put_entry(p, k, i, d);
    endfunction

    function automatic void extract_slot(int unsigned p, ref heap_rsp_t r);
        int unsigned last;
        last = heap_fill;
        r.out_id = hp_id[p]; r.out_key = hp_key[p]; r.out_payload = hp_pl[p];
        id_slot[hp_id[p]] = 0;
        heap_fill = last - 1;
        if (p != last) begin
            put_entry(p, hp_key[last], hp_id[last], hp_pl[last]);
            if (p > 1 && hp_key[p] < hp_key[p/2]) bubble_up(p);
            else bubble_down(p);
        end
    endfunction

    function automatic heap_rsp_t heap_apply(heap_cmd_t c);
        heap_rsp_t r;
        int unsigned cap, p;
        logic signed [31:0] old;
        r = '0;
        r.status = ST_OK;
        cap = cap_reg > HEAP_DEPTH ? HEAP_DEPTH : cap_reg;
        p = (id_slot[c.id] != 0 && id_slot[c.id] <= heap_fill) ? id_slot[c.id] : 0;
        case (c.kind)
            KIND_INSERT: begin
                if (heap_fill >= cap) r.status = ST_FULL;
                else if (p != 0) r.status = ST_DUP;
                else begin
                    heap_fill++;
                    put_entry(heap_fill, c.key, c.id, c.payload);
                    bubble_up(heap_fill);
                end
            end
            KIND_POPMIN: begin
                if (heap_fill == 0) r.status = ST_EMPTY;
                else extract_slot(1, r);
            end
            KIND_SETKEY: begin
                if (p == 0) r.status = ST_NOTFOUND;
                else begin
                    old = hp_key[p];
                    hp_key[p] = c.key;
                    if (c.key < old) bubble_up(p);
                    else bubble_down(p);
                end
            end
            default: begin
                if (p == 0) r.status = ST_NOTFOUND;
                else extract_slot(p, r);
            end
        endcase
        r.entry_count = heap_fill[8:0];
        return r;
    endfunction

    // a beat is accepted on start && !busy at the rising edge
    always @(posedge clk) begin
        if (rst_n && start && !busy) begin
            rsp_expected.push_back(heap_apply(cmd));
            void'(cmd_queue.pop_front());
        end
    end

    // driver: start while busy is simply ignored by the unit
    always @(negedge clk) begin
        if (rst_n) begin
            if (cmd_queue.size() > 0 &&
                !(drain_hold && (busy || rsp_expected.size() > 0)) &&
                $urandom_range(99) >= send_idle_pct) begin
                cmd   <= cmd_queue[0];
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        heap_rsp_t e;
        cycles <= cycles + 1;
        if (rst_n && done) begin
            if (rsp_expected.size() == 0) begin
                $error("result with no expectation: %p", result);
                errors++;
            end else begin
                e = rsp_expected.pop_front();
                if (result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, result.status); errors++;
                end
                if (result.out_id !== e.out_id) begin
                    $error("out_id exp %0d got %0d", e.out_id, result.out_id); errors++;
                end
                if (result.out_key !== e.out_key) begin
                    $error("out_key exp %0d got %0d", e.out_key, result.out_key); errors++;
                end
                if (result.out_payload !== e.out_payload) begin
                    $error("out_payload exp %h got %h", e.out_payload, result.out_payload);
                    errors++;
                end
                if (result.entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d", e.entry_count, result.entry_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (cycles > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_cmd(logic [1:0] k, logic [7:0] i, logic [31:0] key,
                           logic [31:0] pl);
        heap_cmd_t c;
        c.kind = k; c.id = i; c.key = key; c.payload = pl;
        cmd_queue.push_back(c);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || start || rsp_expected.size() > 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_cap(int unsigned v);
        @(negedge clk);
        cfg_data  <= v[8:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cap_reg = v & 32'h1ff;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random ops over ids 0 to id_span; a small span makes hits dominate
    task automatic random_ops(int n, int id_span);
        logic [1:0] k;
        logic [31:0] key;
        for (int j = 0; j < n; j++) begin
            k = $urandom_range(99) < 45 ? KIND_INSERT : 2'($urandom_range(3));
            case ($urandom_range(3))
                0: key = $urandom;
                1: key = $urandom_range(15);
                2: key = {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
                default: key = 32'($signed($urandom_range(20)) - 10);
            endcase
            add_cmd(k, 8'($urandom_range(id_span)), key, $urandom);
        end
    endtask

    initial begin
        int pct [4] = '{0, 59, 0, 8};
        errors = 0; cycles = 0; heap_fill = 0; cap_reg = 256;
        send_idle_pct = 0; drain_hold = 0;
        foreach (id_slot[i]) id_slot[i] = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty cases, extremes, every operation
        add_cmd(KIND_POPMIN, 8'd0, 32'd0, 32'd0);
        add_cmd(KIND_REMOVE, 8'd255, 32'd0, 32'd0);
        add_cmd(KIND_SETKEY, 8'd7, 32'd1, 32'd0);
        add_cmd(KIND_INSERT, 8'd255, 32'h7fff_ffff, 32'hffff_ffff);
        add_cmd(KIND_INSERT, 8'd0, 32'h8000_0000, 32'h0);
        add_cmd(KIND_INSERT, 8'd255, 32'd5, 32'd1);
        add_cmd(KIND_INSERT, 8'd3, 32'd5, 32'haaaa_5555);
        add_cmd(KIND_INSERT, 8'd4, 32'd5, 32'h5555_aaaa);
        add_cmd(KIND_SETKEY, 8'd4, 32'hffff_fff0, 32'd0);
        add_cmd(KIND_SETKEY, 8'd0, 32'd100, 32'd0);
        add_cmd(KIND_REMOVE, 8'd3, 32'd0, 32'd0);
        add_cmd(KIND_REMOVE, 8'd0, 32'd0, 32'd0);
        add_cmd(KIND_POPMIN, 8'd0, 32'd0, 32'd0);
        add_cmd(KIND_POPMIN, 8'd0, 32'd0, 32'd0);
        add_cmd(KIND_POPMIN, 8'd0, 32'd0, 32'd0);
        wait_drained();

        // small capacity, then zero
        write_cap(2);
        add_cmd(KIND_INSERT, 8'd1, 32'd9, 32'd1);
        add_cmd(KIND_INSERT, 8'd2, 32'd8, 32'd2);
        add_cmd(KIND_INSERT, 8'd9, 32'd7, 32'd3);
        add_cmd(KIND_INSERT, 8'd1, 32'd7, 32'd3);
        wait_drained();
        write_cap(0);
        add_cmd(KIND_INSERT, 8'd50, 32'd1, 32'd1);
        add_cmd(KIND_POPMIN, 8'd0, 32'd0, 32'd0);
        add_cmd(KIND_REMOVE, 8'd2, 32'd0, 32'd0);
        wait_drained();

        // random phases over several capacities and idle rates
        for (int ph = 0; ph < 4; ph++) begin
            write_cap(ph == 0 ? 511 : ph == 1 ? 1 : ph == 2 ? 256 : 20);
            send_idle_pct = pct[ph];
            random_ops(ph == 1 ? 60 : 100, ph == 2 ? 255 : 31);
            wait_drained();
        end

        // capacity above the heap depth, with sender held off until results drain
        write_cap(300);
        send_idle_pct = 0;
        random_ops(30, 255);
        drain_hold = 1;
        wait_drained();
        drain_hold = 0;
        random_ops(80, 255);
        wait_drained();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
